// ----- hdl/batt_pct_pkg.sv -----
// Shared types and constants of the battery ADC to percent block.
`default_nettype none

package batt_pct_pkg;

   localparam int ADC_BITS    = 10;
   localparam int MV_W        = 13;
   localparam int PROD_W      = ADC_BITS + MV_W;
   localparam int PCT_W       = 7;
   localparam int CURVE_POINTS = 11;
   localparam int CURVE_STEP  = 10;
   localparam int SEG_W       = 4;
   localparam int SPAN_W      = 7;
   localparam int CSR_IDX_W   = 2;

   localparam logic [CSR_IDX_W-1:0] REG_FULLSCALE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_CLAMP_MIN = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_CLAMP_MAX = 2'd2;

   localparam logic [MV_W-1:0] FULLSCALE_RESET = 13'd6000;
   localparam logic [MV_W-1:0] CLAMP_MIN_RESET = 13'd3300;
   localparam logic [MV_W-1:0] CLAMP_MAX_RESET = 13'd4200;

   localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

   // discharge curve, one point per 10 percent
   localparam logic [MV_W-1:0] CURVE_MV [CURVE_POINTS] = '{
      13'd3600, 13'd3720, 13'd3750, 13'd3780, 13'd3810, 13'd3840,
      13'd3880, 13'd3950, 13'd4020, 13'd4100, 13'd4180
   };

   typedef struct packed {
      logic              read_ok;
      logic [PROD_W-1:0] prod;
   } entry_type;

   typedef struct packed {
      logic [MV_W-1:0] clamp_min_mv;
      logic [MV_W-1:0] clamp_max_mv;
   } clamp_type;

endpackage

`default_nettype wire

// ----- hdl/batt_pct_req_if.sv -----
// Sample channel: valid/ready handshake with the two ADC bytes and read status.
`default_nettype none

interface batt_pct_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] adc_high;
   logic [7:0] adc_low;
   logic       read_ok;

   modport source (output valid, adc_high, adc_low, read_ok, input ready);
   modport sink   (input valid, adc_high, adc_low, read_ok, output ready);
endinterface

`default_nettype wire

// ----- hdl/batt_pct_rsp_if.sv -----
// Result channel: valid/ready handshake with millivolts, percent and error.
`default_nettype none

interface batt_pct_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [batt_pct_pkg::MV_W-1:0]    millivolts;
   logic [batt_pct_pkg::PCT_W-1:0]   percent;
   logic                             error;

   modport source (output valid, millivolts, percent, error, input ready);
   modport sink   (input valid, millivolts, percent, error, output ready);
endinterface

`default_nettype wire

// ----- hdl/batt_pct_front.sv -----
// Front stage: accepts a sample, builds the raw code and registers raw times full scale.
`default_nettype none

module batt_pct_front (
   input  wire logic                            clock,
   input  wire logic                            reset,
   batt_pct_req_if.sink                         req_ch,
   input  wire logic [batt_pct_pkg::MV_W-1:0]   fullscale_mv,
   output batt_pct_pkg::entry_type              push_data,
   output logic                                 push_valid,
   input  wire logic                            push_ready
);

   logic                                  valid_ff;
   batt_pct_pkg::entry_type               data_ff;
   batt_pct_pkg::entry_type               data_in;
   logic [batt_pct_pkg::ADC_BITS-1:0]     raw;

   assign req_ch.ready = !valid_ff || push_ready;
   assign push_valid   = valid_ff;
   assign push_data    = data_ff;

   always_comb begin
      raw             = {req_ch.adc_high, req_ch.adc_low[1:0]};
      data_in.read_ok = req_ch.read_ok;
      data_in.prod    = {{batt_pct_pkg::MV_W{1'b0}}, raw}
                        * {{batt_pct_pkg::ADC_BITS{1'b0}}, fullscale_mv};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         valid_ff <= req_ch.valid;
      end
      if (req_ch.valid && req_ch.ready) begin
         data_ff <= data_in;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/batt_pct_queue.sv -----
// Short FIFO between the front and back stages.
`default_nettype none

module batt_pct_queue #(
   parameter int DEPTH = 2
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire batt_pct_pkg::entry_type push_data,
   input  wire logic                    push_valid,
   output logic                         push_ready,
   output batt_pct_pkg::entry_type      pop_data,
   output logic                         pop_valid,
   input  wire logic                    pop_ready
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   batt_pct_pkg::entry_type mem_ff [DEPTH];
   logic [PTR_W-1:0]        wr_ptr_ff;
   logic [PTR_W-1:0]        rd_ptr_ff;
   logic [CNT_W-1:0]        count_ff;
   logic                    do_push;
   logic                    do_pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/batt_pct_back.sv -----
// Back stages: clamp and curve segment, then interpolation into the result register.
`default_nettype none

module batt_pct_back (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire batt_pct_pkg::entry_type pop_data,
   input  wire logic                    pop_valid,
   output logic                         pop_ready,
   input  wire batt_pct_pkg::clamp_type clamps,
   batt_pct_rsp_if.source               rsp_ch
);

   localparam int MV_W   = batt_pct_pkg::MV_W;
   localparam int SEG_W  = batt_pct_pkg::SEG_W;
   localparam int SPAN_W = batt_pct_pkg::SPAN_W;
   localparam int PCT_W  = batt_pct_pkg::PCT_W;
   localparam int LHS_W  = SPAN_W + 4;
   localparam int LAST   = batt_pct_pkg::CURVE_POINTS - 1;

   // stage 1 registers
   logic              s1_valid_ff;
   logic              s1_ok_ff;
   logic [MV_W-1:0]   s1_mv_ff;
   logic              s1_below_ff;
   logic              s1_above_ff;
   logic [SEG_W-1:0]  s1_seg_ff;
   logic [SPAN_W-1:0] s1_into_ff;
   logic [SPAN_W-1:0] s1_span_ff;

   // output registers
   logic              out_valid_ff;
   logic [MV_W-1:0]   out_mv_ff;
   logic [PCT_W-1:0]  out_pct_ff;
   logic              out_err_ff;

   logic              adv1;
   logic              adv2;

   logic [MV_W-1:0]   mv_scaled;
   logic [MV_W-1:0]   mv_in;
   logic              below_in;
   logic              above_in;
   logic [SEG_W-1:0]  seg_in;
   logic [SPAN_W-1:0] into_in;
   logic [SPAN_W-1:0] span_in;

   logic [LHS_W-1:0]  lhs;
   logic [SEG_W-1:0]  digit;
   logic [PCT_W-1:0]  pct_in;

   assign adv2      = !out_valid_ff || rsp_ch.ready;
   assign adv1      = !s1_valid_ff || adv2;
   assign pop_ready = adv1;

   // clamp, min first, then find the curve segment
   always_comb begin
      mv_scaled = pop_data.prod[batt_pct_pkg::PROD_W-1:batt_pct_pkg::ADC_BITS];
      if (mv_scaled < clamps.clamp_min_mv) begin
         mv_in = clamps.clamp_min_mv;
      end else if (mv_scaled > clamps.clamp_max_mv) begin
         mv_in = clamps.clamp_max_mv;
      end else begin
         mv_in = mv_scaled;
      end
      below_in = (mv_in <= batt_pct_pkg::CURVE_MV[0]);
      above_in = (mv_in >= batt_pct_pkg::CURVE_MV[LAST]);
      seg_in   = '0;
      for (int k = 1; k < LAST; k++) begin
         if (mv_in >= batt_pct_pkg::CURVE_MV[k]) begin
            seg_in = seg_in + 1'b1;
         end
      end
      into_in = SPAN_W'(mv_in - batt_pct_pkg::CURVE_MV[seg_in]);
      span_in = SPAN_W'(batt_pct_pkg::CURVE_MV[seg_in + 1'b1]
                        - batt_pct_pkg::CURVE_MV[seg_in]);
   end

   // rounded (into*10 + span/2) / span as a count of thresholds passed
   always_comb begin
      lhs = {4'd0, s1_into_ff} * LHS_W'(batt_pct_pkg::CURVE_STEP)
            + {5'd0, s1_span_ff[SPAN_W-1:1]};
      digit = '0;
      for (int j = 1; j <= batt_pct_pkg::CURVE_STEP; j++) begin
         if (lhs >= LHS_W'(j) * {4'd0, s1_span_ff}) begin
            digit = digit + 1'b1;
         end
      end
      if (s1_below_ff) begin
         pct_in = '0;
      end else if (s1_above_ff) begin
         pct_in = batt_pct_pkg::PCT_FULL;
      end else begin
         pct_in = {3'd0, s1_seg_ff} * PCT_W'(batt_pct_pkg::CURVE_STEP) + {3'd0, digit};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (adv1) begin
            s1_valid_ff <= pop_valid;
         end
         if (adv2) begin
            out_valid_ff <= s1_valid_ff;
         end
      end
      if (adv1 && pop_valid) begin
         s1_ok_ff    <= pop_data.read_ok;
         s1_mv_ff    <= mv_in;
         s1_below_ff <= below_in;
         s1_above_ff <= above_in;
         s1_seg_ff   <= seg_in;
         s1_into_ff  <= into_in;
         s1_span_ff  <= span_in;
      end
      if (adv2 && s1_valid_ff) begin
         if (s1_ok_ff) begin
            out_mv_ff  <= s1_mv_ff;
            out_pct_ff <= pct_in;
            out_err_ff <= 1'b0;
         end else begin
            out_mv_ff  <= '0;
            out_pct_ff <= '0;
            out_err_ff <= 1'b1;
         end
      end
   end

   assign rsp_ch.valid      = out_valid_ff;
   assign rsp_ch.millivolts = out_mv_ff;
   assign rsp_ch.percent    = out_pct_ff;
   assign rsp_ch.error      = out_err_ff;

endmodule

`default_nettype wire

// ----- hdl/battery_adc_to_percent.sv -----
// Path: front register, queue (QUEUE_DEPTH items), stage 1 register, result register.
// Throughput: one sample per cycle while the result side is ready; the front multiply,
//   clamp/segment and interpolation stages hold one item each; all advance independently.
// Reset: synchronous, active high; clears all valid flags and queue pointers and loads
//   the registers with 6000 / 3300 / 4200 mV.
// Top level of the battery ADC to percent fuel gauge.
`default_nettype none

module battery_adc_to_percent #(
   parameter int QUEUE_DEPTH = 2
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   batt_pct_req_if.sink                              req_ch,
   batt_pct_rsp_if.source                            rsp_ch,
   input  wire logic                                 csr_we,
   input  wire logic [batt_pct_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [batt_pct_pkg::MV_W-1:0]        csr_wdata
);

   logic [batt_pct_pkg::MV_W-1:0] fullscale_ff;
   batt_pct_pkg::clamp_type       clamps_ff;

   batt_pct_pkg::entry_type       push_data;
   logic                          push_valid;
   logic                          push_ready;
   batt_pct_pkg::entry_type       pop_data;
   logic                          pop_valid;
   logic                          pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         fullscale_ff           <= batt_pct_pkg::FULLSCALE_RESET;
         clamps_ff.clamp_min_mv <= batt_pct_pkg::CLAMP_MIN_RESET;
         clamps_ff.clamp_max_mv <= batt_pct_pkg::CLAMP_MAX_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            batt_pct_pkg::REG_FULLSCALE: fullscale_ff           <= csr_wdata;
            batt_pct_pkg::REG_CLAMP_MIN: clamps_ff.clamp_min_mv <= csr_wdata;
            batt_pct_pkg::REG_CLAMP_MAX: clamps_ff.clamp_max_mv <= csr_wdata;
            default: ;
         endcase
      end
   end

   batt_pct_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_ch       (req_ch),
      .fullscale_mv (fullscale_ff),
      .push_data    (push_data),
      .push_valid   (push_valid),
      .push_ready   (push_ready)
   );

   batt_pct_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_data  (push_data),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .pop_data   (pop_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready)
   );

   batt_pct_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_data  (pop_data),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .clamps    (clamps_ff),
      .rsp_ch    (rsp_ch)
   );

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.error |-> rsp_ch.millivolts == '0 && rsp_ch.percent == '0)
      else $error("error item carries nonzero values");

   a_pct_range: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> rsp_ch.percent <= batt_pct_pkg::PCT_FULL)
      else $error("percent above full");

   a_curve_low: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.error && rsp_ch.millivolts <= batt_pct_pkg::CURVE_MV[0]
      |-> rsp_ch.percent == '0)
      else $error("percent nonzero at bottom of curve");

   a_curve_high: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.error
      && rsp_ch.millivolts >= batt_pct_pkg::CURVE_MV[batt_pct_pkg::CURVE_POINTS - 1]
      |-> rsp_ch.percent == batt_pct_pkg::PCT_FULL)
      else $error("percent not full at top of curve");

endmodule

`default_nettype wire

// ----- test/tb.sv -----
// Self-checking testbench for the battery ADC to percent fuel gauge.
`default_nettype none

module tb;

   localparam int MV_W = batt_pct_pkg::MV_W;
   localparam int PCT_W = batt_pct_pkg::PCT_W;
   localparam int IDX_W = batt_pct_pkg::CSR_IDX_W;
   localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;
   localparam int IDLE_PCT = 24;
   localparam int HOLD_CYCLES = 80;

   typedef struct packed {
      logic [MV_W-1:0]  millivolts;
      logic [PCT_W-1:0] percent;
      logic             error;
   } gauge_reading_type;

   class fuel_gauge_checker_type;
      gauge_reading_type expected_readings[$];
      logic [MV_W-1:0]   fullscale;
      logic [MV_W-1:0]   clamp_min;
      logic [MV_W-1:0]   clamp_max;
      int                failures;
      int                readings_checked;
      int                read_errors;
      int                full_count;
      int                empty_count;
      int unsigned       discharge_mv[batt_pct_pkg::CURVE_POINTS];

      function new();
         fullscale = 13'd6000;
         clamp_min = 13'd3300;
         clamp_max = 13'd4200;
         discharge_mv = '{3600, 3720, 3750, 3780, 3810, 3840, 3880, 3950, 4020, 4100, 4180};
      endfunction

      function void set_reg(logic [IDX_W-1:0] idx, logic [MV_W-1:0] value);
         case (idx)
            batt_pct_pkg::REG_FULLSCALE: fullscale = value;
            batt_pct_pkg::REG_CLAMP_MIN: clamp_min = value;
            batt_pct_pkg::REG_CLAMP_MAX: clamp_max = value;
            default: ;
         endcase
      endfunction

      function int pending();
         return expected_readings.size();
      endfunction

      function int unsigned mv_to_charge(int unsigned mv);
         int unsigned span;
         int unsigned into;
         if (mv <= discharge_mv[0]) return 0;
         for (int k = 1; k < batt_pct_pkg::CURVE_POINTS; k++) begin
            if (mv < discharge_mv[k]) begin
               span = discharge_mv[k] - discharge_mv[k-1];
               into = mv - discharge_mv[k-1];
               return (k - 1) * 10 + (into * 10 + span / 2) / span;
            end
         end
         return 100;
      endfunction

      function gauge_reading_type predict_reading(logic [7:0] adc_high, logic [7:0] adc_low,
                                                  logic read_ok);
         gauge_reading_type r;
         int unsigned       raw;
         int unsigned       mv;
         r = '0;
         if (!read_ok) begin
            r.error = 1'b1;
            return r;
         end
         raw = 32'({adc_high, adc_low[1:0]});
         mv = (raw * fullscale) >> 10;
         if (mv < clamp_min) mv = clamp_min;
         else if (mv > clamp_max) mv = clamp_max;
         r.millivolts = mv[MV_W-1:0];
         r.percent = PCT_W'(mv_to_charge(mv));
         return r;
      endfunction

      function void note_sample(logic [7:0] adc_high, logic [7:0] adc_low, logic read_ok);
         expected_readings.push_back(predict_reading(adc_high, adc_low, read_ok));
      endfunction

      function void report(string what, gauge_reading_type want, gauge_reading_type got);
         failures++;
         if (failures <= 10)
            $display("tb: %s: expected mv=%0d pct=%0d err=%0d, got mv=%0d pct=%0d err=%0d",
                     what, want.millivolts, want.percent, want.error,
                     got.millivolts, got.percent, got.error);
      endfunction

      function void check_result(gauge_reading_type got);
         gauge_reading_type want;
         if (expected_readings.size() == 0) begin
            report("result with nothing outstanding", '0, got);
            return;
         end
         want = expected_readings.pop_front();
         readings_checked++;
         if (want.error) read_errors++;
         else if (want.percent == 0) empty_count++;
         else if (want.percent == batt_pct_pkg::PCT_FULL) full_count++;
         if (got.millivolts !== want.millivolts || got.percent !== want.percent ||
             got.error !== want.error)
            report("mismatch", want, got);
      endfunction

      function void close_out();
         if (expected_readings.size() != 0) begin
            failures += expected_readings.size();
            $display("tb: %0d results never arrived", expected_readings.size());
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic csr_we;
   logic [IDX_W-1:0] csr_index;
   logic [MV_W-1:0] csr_wdata;
   logic no_idle;
   int   hold_requests = 0;
   int   holds_served = 0;
   int   hold_left = 0;
   int   settings_used;

   fuel_gauge_checker_type gauge;

   batt_pct_req_if req_ch ();
   batt_pct_rsp_if rsp_ch ();

   battery_adc_to_percent dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial clock = 1'b0;
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      #2000000;
      $display("tb: timeout");
      $display("tb: FAIL");
      $finish;
   end

   // result side: random stalls, plus a long hold-off on request
   always @(posedge clock) begin
      if (hold_requests != holds_served) begin
         holds_served = hold_requests;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
      end
   end

   // handshakes sampled at the edge, before any update of this step lands
   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready)
            gauge.note_sample(req_ch.adc_high, req_ch.adc_low, req_ch.read_ok);
         if (rsp_ch.valid && rsp_ch.ready)
            gauge.check_result('{rsp_ch.millivolts, rsp_ch.percent, rsp_ch.error});
      end
   end

   task automatic send_sample(logic [7:0] adc_high, logic [7:0] adc_low, logic read_ok);
      while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.adc_high <= adc_high;
      req_ch.adc_low <= adc_low;
      req_ch.read_ok <= read_ok;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   task automatic send_raw(int unsigned raw, logic read_ok);
      logic [7:0] adc_low;
      adc_low = 8'($urandom());
      adc_low[1:0] = raw[1:0];
      send_sample(raw[9:2], adc_low, read_ok);
   endtask

   // most samples land near the discharge curve so every segment is hit
   task automatic send_random();
      int unsigned raw;
      int unsigned lo_raw;
      int unsigned hi_raw;
      logic        read_ok;
      read_ok = ($urandom_range(0, 99) >= 12);
      if (gauge.fullscale != 0 && $urandom_range(0, 99) < 60) begin
         lo_raw = 3500 * 1024 / gauge.fullscale;
         hi_raw = 4300 * 1024 / gauge.fullscale + 1;
         if (lo_raw > 1023) lo_raw = 1023;
         if (hi_raw > 1023) hi_raw = 1023;
         raw = $urandom_range(hi_raw, lo_raw);
      end else begin
         raw = $urandom_range(1023, 0);
      end
      send_raw(raw, read_ok);
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (gauge.pending() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   // registers are only touched with the pipe empty
   task automatic apply_setting(logic [MV_W-1:0] fullscale, logic [MV_W-1:0] clamp_min,
                                logic [MV_W-1:0] clamp_max);
      logic [MV_W-1:0] junk;
      junk = MV_W'($urandom());
      csr_we <= 1'b1;
      csr_index <= batt_pct_pkg::REG_FULLSCALE;
      csr_wdata <= fullscale;
      @(posedge clock);
      csr_index <= batt_pct_pkg::REG_CLAMP_MIN;
      csr_wdata <= clamp_min;
      @(posedge clock);
      csr_index <= batt_pct_pkg::REG_CLAMP_MAX;
      csr_wdata <= clamp_max;
      @(posedge clock);
      csr_index <= REG_UNUSED;
      csr_wdata <= junk;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      gauge.set_reg(batt_pct_pkg::REG_FULLSCALE, fullscale);
      gauge.set_reg(batt_pct_pkg::REG_CLAMP_MIN, clamp_min);
      gauge.set_reg(batt_pct_pkg::REG_CLAMP_MAX, clamp_max);
      gauge.set_reg(REG_UNUSED, junk);
      settings_used++;
   endtask

   task automatic random_phase(logic [MV_W-1:0] fullscale, logic [MV_W-1:0] clamp_min,
                               logic [MV_W-1:0] clamp_max, int count);
      drain();
      apply_setting(fullscale, clamp_min, clamp_max);
      repeat (count) send_random();
   endtask

   initial begin
      int waited;
      gauge = new();
      reset <= 1'b1;
      csr_we <= 1'b0;
      csr_index <= batt_pct_pkg::REG_FULLSCALE;
      csr_wdata <= '0;
      req_ch.valid <= 1'b0;
      req_ch.adc_high <= '0;
      req_ch.adc_low <= '0;
      req_ch.read_ok <= 1'b0;
      no_idle = 1'b0;
      settings_used = 1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset values: clamp floor, clamp ceiling, failed reads, curve start
      send_sample(8'd0, 8'd0, 1'b1);
      send_sample(8'd255, 8'd255, 1'b1);
      send_sample(8'd255, 8'd3, 1'b1);
      send_sample(8'd0, 8'd252, 1'b1);
      send_sample(8'd153, 8'd2, 1'b1);
      send_sample(8'd153, 8'd3, 1'b1);
      send_sample(8'd170, 8'd0, 1'b1);
      send_sample(8'd0, 8'd0, 1'b0);
      send_sample(8'd255, 8'd255, 1'b0);
      send_sample(8'd170, 8'd170, 1'b0);

      // mv = 4 * raw with the clamps wide open: exact curve points and rounding
      drain();
      apply_setting(13'd4096, 13'd0, 13'h1FFF);
      send_raw(900, 1'b1);
      send_raw(901, 1'b1);
      send_raw(930, 1'b1);
      send_raw(937, 1'b1);
      send_raw(1014, 1'b1);
      send_raw(1015, 1'b1);
      send_raw(1023, 1'b1);
      send_raw(0, 1'b1);
      send_raw(1, 1'b1);
      send_raw(1023, 1'b0);

      // back to reset values; long result stall, full pause, then back to back
      random_phase(13'd6000, 13'd3300, 13'd4200, 100);
      hold_requests++;
      repeat (120) send_random();
      drain();
      repeat (80) send_random();
      no_idle = 1'b1;
      repeat (150) send_random();
      no_idle = 1'b0;

      random_phase(13'h1FFF, 13'd0, 13'h1FFF, 250);
      random_phase(13'd0, 13'd0, 13'h1FFF, 60);
      random_phase(13'd6000, 13'd4000, 13'd3700, 200);
      random_phase(13'd1000, 13'd0, 13'h1FFF, 120);
      random_phase(13'd5000, 13'h1FFF, 13'd0, 50);
      random_phase(13'd6000, 13'd0, 13'd0, 50);
      for (int p = 0; p < 5; p++)
         random_phase(MV_W'($urandom_range(8191, 1000)), MV_W'($urandom_range(3700, 0)),
                      MV_W'($urandom_range(8191, 3600)), 120);

      req_ch.valid <= 1'b0;
      waited = 0;
      while (gauge.pending() != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      repeat (8) @(posedge clock);
      gauge.close_out();

      $display("tb: %0d readings checked over %0d register settings", gauge.readings_checked,
               settings_used);
      $display("tb: %0d failed reads, %0d at empty, %0d at full charge", gauge.read_errors,
               gauge.empty_count, gauge.full_count);
      if (gauge.failures == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: %0d failures", gauge.failures);
         $display("tb: FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ----- sim.f -----
hdl/batt_pct_pkg.sv
hdl/batt_pct_req_if.sv
hdl/batt_pct_rsp_if.sv
hdl/batt_pct_front.sv
hdl/batt_pct_queue.sv
hdl/batt_pct_back.sv
hdl/battery_adc_to_percent.sv
test/tb.sv
